@@ hdl/averaged_hysteresis_thermostat_assert.svh @@
// Assertion macros shared by the thermostat RTL.
`ifndef AVERAGED_HYSTERESIS_THERMOSTAT_ASSERT_SVH
`define AVERAGED_HYSTERESIS_THERMOSTAT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AHTH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AHTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ahth_pkg.sv @@
// Types and constants for the averaged hysteresis thermostat.
package ahth_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int CMD_W      = 2;
  localparam int WINDOW_DEF = 100;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_ADDR_W-1:0] REG_LOW  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH = 1'b1;

  localparam logic [CFG_DATA_W-1:0] LOW_RST  = 12'd372;
  localparam logic [CFG_DATA_W-1:0] HIGH_RST = 12'd447;

  typedef enum logic [CMD_W-1:0] {
    CMD_HOLD = 2'd0,
    CMD_AUTO = 2'd1,
    CMD_ON   = 2'd2,
    CMD_OFF  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic refresh;
  } item_t;

endpackage

@@ hdl/averaged_hysteresis_thermostat.sv @@
// Top level: moving-average thermostat with a hysteresis lamp control.
//
// Input stream: each word carries a 12-bit converter sample, a 2-bit command
// (hold, automatic, force on, force off) and a refresh flag. The sample
// enters a WINDOW-deep chain of cells; a running sum drops the sample leaving
// the chain and adds the new one. On refresh the held average becomes
// floor(sum / WINDOW), taken by a constant reciprocal multiply.
// Output stream: one word per input word with lamp level, host status and
// the held average. Automatic control compares the average held before
// this word's refresh against the low and high thresholds.
// Registers from input accept to output valid: sum register, reciprocal
// product register, output register. Throughput: one word per cycle while
// out_tready is high; the multiply is pipelined and the only feedback loops
// are the running sum and the control update in the output stage.
// Stall: each stage holds its word while the next is full; empty stages
// still take new words, so input stalls only after the pipeline fills.
// Reset (synchronous, rst_n low): cells marked empty (read as zero), sum,
// average, lamp and status cleared, thresholds back to 372 and 447.
// Configuration writes take effect at once; write them only while idle.
module averaged_hysteresis_thermostat #(
  parameter int WINDOW = ahth_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // [11:0] sample, [15:12] zero
  input  logic [2:0]                     in_tuser,  // [1:0] cmd, [2] refresh
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata, // [0] lamp_on, [1] reported_status,
                                                    // [13:2] average_count, [15:14] zero
  input  logic                           cfg_we,
  input  logic [ahth_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ahth_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ahth_pkg::*;

  localparam int SUM_W  = $clog2(SAMPLE_MAX * WINDOW + 1);
  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SH     = SUM_W + LOG_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // configuration
  logic [CFG_DATA_W-1:0] low_r, high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_RST;
      high_r <= HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LOW:  low_r  <= cfg_wdata;
        REG_HIGH: high_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // pipeline handshake
  logic s1_vld_r, s2_vld_r, out_vld_r;
  logic out_load, s2_load, s1_load;

  assign out_load  = s2_vld_r && (!out_vld_r || out_tready);
  assign s2_load   = s1_vld_r && (!s2_vld_r || out_load);
  assign in_tready = !s1_vld_r || s2_load;
  assign s1_load   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (!s2_vld_r || out_load) begin
        s2_vld_r <= s1_vld_r;
      end
      if (!out_vld_r || out_tready) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  // stage 1: sample chain and running sum
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] oldest;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  item_t               in_item;
  item_t               s1_item_r;

  assign sample          = in_tdata[SAMPLE_W-1:0];
  assign in_item.cmd     = cmd_t'(in_tuser[CMD_W-1:0]);
  assign in_item.refresh = in_tuser[CMD_W];

  ahth_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (s1_load),
    .sample (sample),
    .oldest (oldest)
  );

  assign sum_nxt = sum_r - SUM_W'(oldest) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (s1_load) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= in_item;
    end
  end

  // stage 2: reciprocal product; the shift gives the exact floor quotient
  logic [PROD_W-1:0]   s2_prod_r;
  item_t               s2_item_r;
  logic [SAMPLE_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_prod_r <= PROD_W'(sum_r) * PROD_W'(RECIP);
      s2_item_r <= s1_item_r;
    end
  end

  assign quot = SAMPLE_W'(s2_prod_r >> SH);

  // stage 3: control and output register
  logic                lamp, status;
  logic [SAMPLE_W-1:0] avg;

  ahth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .item     (s2_item_r),
    .quot     (quot),
    .low_thr  (low_r),
    .high_thr (high_r),
    .lamp     (lamp),
    .status   (status),
    .avg      (avg)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, avg, status, lamp};

  `include "averaged_hysteresis_thermostat_assert.svh"

  `AHTH_ASSERT_NEXT(a_force_on, out_load && s2_item_r.cmd == CMD_ON,
    lamp && status, "forced-on word did not drive lamp and status high")
  `AHTH_ASSERT_NEXT(a_force_off, out_load && s2_item_r.cmd == CMD_OFF,
    !lamp && !status, "forced-off word did not drive lamp and status low")
  `AHTH_ASSERT_NEXT(a_hold_lamp, out_load && s2_item_r.cmd == CMD_HOLD,
    $stable(lamp) && $stable(status), "hold word changed the lamp or status")
  `AHTH_ASSERT_NOW(a_sum_range, 1'b1,
    sum_r <= SUM_W'(SAMPLE_MAX * WINDOW), "running sum exceeds a full window")

endmodule

@@ hdl/ahth_cell.sv @@
// One cell of the sample shift line: a sample and its filled flag.
module ahth_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift,
  input  logic [ahth_pkg::SAMPLE_W-1:0] din,
  input  logic                         din_vld,
  output logic [ahth_pkg::SAMPLE_W-1:0] dout,
  output logic                         dout_vld
);
  import ahth_pkg::*;

  logic [SAMPLE_W-1:0] data_r;
  logic                vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift) begin
      vld_r <= din_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= din;
    end
  end

  assign dout     = data_r;
  assign dout_vld = vld_r;

endmodule

@@ hdl/ahth_ring.sv @@
// Chain of sample cells; the last cell gives the sample leaving the window.
module ahth_ring #(
  parameter int WINDOW = ahth_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift,
  input  logic [ahth_pkg::SAMPLE_W-1:0] sample,
  output logic [ahth_pkg::SAMPLE_W-1:0] oldest
);
  import ahth_pkg::*;

  logic [SAMPLE_W-1:0] tap_data [WINDOW+1];
  logic                tap_vld  [WINDOW+1];

  assign tap_data[0] = sample;
  assign tap_vld[0]  = 1'b1;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    ahth_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .din      (tap_data[i]),
      .din_vld  (tap_vld[i]),
      .dout     (tap_data[i+1]),
      .dout_vld (tap_vld[i+1])
    );
  end

  // a cell not yet filled since reset reads as zero
  assign oldest = tap_vld[WINDOW] ? tap_data[WINDOW] : '0;

endmodule

@@ hdl/ahth_ctrl.sv @@
// Output stage: command decode, hysteresis control and held average.
module ahth_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  ahth_pkg::item_t                item,
  input  logic [ahth_pkg::SAMPLE_W-1:0]   quot,
  input  logic [ahth_pkg::CFG_DATA_W-1:0] low_thr,
  input  logic [ahth_pkg::CFG_DATA_W-1:0] high_thr,
  output logic                           lamp,
  output logic                           status,
  output logic [ahth_pkg::SAMPLE_W-1:0]   avg
);
  import ahth_pkg::*;

  logic                ctl_r, ctl_nxt;
  logic                lamp_r, lamp_nxt;
  logic                stat_r, stat_nxt;
  logic [SAMPLE_W-1:0] held_r, held_nxt;

  always_comb begin
    ctl_nxt  = ctl_r;
    lamp_nxt = lamp_r;
    stat_nxt = stat_r;
    held_nxt = held_r;
    unique case (item.cmd)
      CMD_HOLD: begin
      end
      CMD_AUTO: begin
        // below low wins when the thresholds cross
        priority if (held_r < low_thr) begin
          lamp_nxt = 1'b1;
          ctl_nxt  = 1'b1;
        end else if (held_r > high_thr) begin
          lamp_nxt = 1'b0;
          ctl_nxt  = 1'b0;
        end else begin
          // hold lamp and control inside the band
        end
        stat_nxt = ctl_nxt;
      end
      CMD_ON: begin
        lamp_nxt = 1'b1;
        stat_nxt = 1'b1;
      end
      CMD_OFF: begin
        lamp_nxt = 1'b0;
        stat_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    // refresh comes after the command, so control sees the old average
    if (item.refresh) begin
      held_nxt = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= 1'b0;
      lamp_r <= 1'b0;
      stat_r <= 1'b0;
      held_r <= '0;
    end else if (load) begin
      ctl_r  <= ctl_nxt;
      lamp_r <= lamp_nxt;
      stat_r <= stat_nxt;
      held_r <= held_nxt;
    end
  end

  assign lamp   = lamp_r;
  assign status = stat_r;
  assign avg    = held_r;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the averaged hysteresis thermostat stream block.
`timescale 1ns / 100ps

module testbench;
  import ahth_pkg::*;

  localparam int WIN       = WINDOW_DEF;
  localparam int SETTLE    = 8;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic        lamp;
    logic        heating;
    logic [11:0] avg;
  } lamp_report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [11:0] sample, [15:12] zero
  logic [2:0]            in_tuser;   // [1:0] cmd, [2] refresh
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // [0] lamp_on, [1] reported_status,
                                     // [13:2] average_count, [15:14] zero
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Thermostat shadow state
  logic [11:0]  ring [WIN];
  int unsigned  slot;
  logic [18:0]  win_sum;
  logic [11:0]  avg_held;
  logic [11:0]  low_thr;
  logic [11:0]  high_thr;
  logic         ctrl_st;
  logic         lamp_lvl;
  logic         stat_flag;

  lamp_report_t lamp_reports [$];
  lamp_report_t want;

  int  src_gap_pct;
  int  sink_gap_pct;
  bit  stall_request;
  int  mismatches;
  int  words_sent;
  int  words_checked;
  int  reg_writes;
  int  ready_low_seen;

  averaged_hysteresis_thermostat dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Ring and running sum first, then the command on the old average, then refresh.
  function automatic lamp_report_t advance_thermostat(logic [11:0] smp, cmd_t c, logic rf);
    lamp_report_t rep;
    win_sum    = win_sum - 19'(ring[slot]) + 19'(smp);
    ring[slot] = smp;
    slot       = (slot == WIN - 1) ? 0 : slot + 1;
    case (c)
      CMD_AUTO: begin
        if (avg_held < low_thr) begin
          lamp_lvl = 1'b1;
          ctrl_st  = 1'b1;
        end else if (avg_held > high_thr) begin
          lamp_lvl = 1'b0;
          ctrl_st  = 1'b0;
        end
        stat_flag = ctrl_st;
      end
      CMD_ON: begin
        lamp_lvl  = 1'b1;
        stat_flag = 1'b1;
      end
      CMD_OFF: begin
        lamp_lvl  = 1'b0;
        stat_flag = 1'b0;
      end
      CMD_HOLD: ;
    endcase
    if (rf) avg_held = 12'(win_sum / WIN);
    rep.lamp    = lamp_lvl;
    rep.heating = stat_flag;
    rep.avg     = avg_held;
    return rep;
  endfunction

  function automatic int clamp_count(int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  task automatic send_word(input logic [11:0] smp, input cmd_t c, input logic rf);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tdata  <= {4'd0, smp};
    in_tuser  <= {rf, c};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) begin
      ready_low_seen++;
      @(posedge clk);
    end
    lamp_reports.push_back(advance_thermostat(smp, c, rf));
    words_sent++;
  endtask

  // Let the pipeline drain before touching registers.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (lamp_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_LOW) low_thr = val;
    else high_thr = val;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic write_thresholds(input logic [11:0] lo, input logic [11:0] hi);
    wait_idle();
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
  endtask

  task automatic test_power_on();
    send_word(12'd0, CMD_HOLD, 1'b0);
    send_word(12'hFFF, CMD_AUTO, 1'b1);
    send_word(12'hFFF, CMD_OFF, 1'b0);
    send_word(12'd0, CMD_AUTO, 1'b0);
  endtask

  task automatic test_forced_commands();
    send_word(12'd2048, CMD_ON, 1'b1);
    send_word(12'd1, CMD_HOLD, 1'b1);
    send_word(12'hFFF, CMD_OFF, 1'b1);
    send_word(12'hAAA, CMD_HOLD, 1'b0);
    send_word(12'h555, CMD_AUTO, 1'b1);
  endtask

  // Crossed and extreme thresholds.
  task automatic test_threshold_corners();
    write_thresholds(12'hFFF, 12'd0);
    send_word(12'hFFF, CMD_AUTO, 1'b1);
    send_word(12'hFFF, CMD_AUTO, 1'b1);
    write_thresholds(12'd0, 12'd0);
    send_word(12'd0, CMD_AUTO, 1'b0);
    send_word(12'd0, CMD_AUTO, 1'b1);
    write_thresholds(12'd0, 12'hFFF);
    send_word(12'h800, CMD_ON, 1'b0);
    send_word(12'h7FF, CMD_AUTO, 1'b1);
    send_word(12'd0, CMD_OFF, 1'b0);
    send_word(12'd0, CMD_AUTO, 1'b1);
  endtask

  // Mostly runs of samples that settle around a target near the thresholds,
  // driven by automatic control with a periodic refresh; some noise mixed in.
  task automatic run_profiles(input int n_items);
    int   done, len, k, lo, hi, target, spread, period;
    cmd_t c;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 12);
        if (len > n_items - done) len = n_items - done;
        for (k = 0; k < len; k++)
          send_word(12'($urandom), cmd_t'($urandom_range(0, 3)), 1'($urandom));
      end else begin
        len = $urandom_range(20, 130);
        if (len > n_items - done) len = n_items - done;
        lo  = (low_thr < high_thr) ? int'(low_thr) : int'(high_thr);
        hi  = (low_thr < high_thr) ? int'(high_thr) : int'(low_thr);
        if ($urandom_range(0, 4) == 0) target = $urandom_range(0, SAMPLE_MAX);
        else target = clamp_count(lo - 300 + int'($urandom_range(0, hi - lo + 600)));
        spread = ($urandom_range(0, 3) == 0) ? 2000 : $urandom_range(0, 80);
        period = $urandom_range(1, 25);
        for (k = 0; k < len; k++) begin
          c = ($urandom_range(0, 99) < 85) ? CMD_AUTO : cmd_t'($urandom_range(0, 3));
          send_word(12'(clamp_count(target - spread + int'($urandom_range(0, 2 * spread)))),
                    c, 1'(k % period == period - 1));
        end
      end
      done += len;
    end
  endtask

  task automatic test_random_batches();
    int b;
    logic [11:0] a, z;
    for (b = 0; b < 5; b++) begin
      case (b)
        0: write_thresholds(LOW_RST, HIGH_RST);
        1: write_thresholds(12'd0, 12'hFFF);
        2: begin
          a = 12'($urandom);
          z = 12'($urandom);
          write_thresholds(a, z);
        end
        3: begin
          a = 12'($urandom_range(0, 3000));
          write_thresholds(a, a + 12'($urandom_range(0, 400)));
        end
        default: begin
          a = 12'($urandom_range(200, 4095));
          write_thresholds(a, a - 12'($urandom_range(1, 200)));
        end
      endcase
      src_gap_pct  = (b == 1) ? 0 : $urandom_range(3, 25);
      sink_gap_pct = (b == 3) ? 0 : $urandom_range(3, 25);
      run_profiles(300);
    end
  endtask

  // Hold the output off for a long stretch while words keep coming.
  task automatic test_backpressure();
    write_thresholds(LOW_RST, HIGH_RST);
    src_gap_pct   = 0;
    stall_request = 1'b1;
    run_profiles(100);
  endtask

  task automatic test_closing_burst();
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    run_profiles(250);
  endtask

  initial begin : sink_ready
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        out_tready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        stall_request = 1'b0;
        out_tready <= 1'b1;
      end else if (sink_gap_pct != 0 && $urandom_range(0, 99) < sink_gap_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (lamp_reports.size() == 0) begin
        if (mismatches < 20) $display("%0t: unexpected word %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = lamp_reports.pop_front();
        words_checked++;
        if (out_tdata[0] !== want.lamp) begin
          if (mismatches < 20)
            $display("%0t: lamp_on expected %0b got %0b", $time, want.lamp, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[1] !== want.heating) begin
          if (mismatches < 20)
            $display("%0t: status expected %0b got %0b", $time, want.heating, out_tdata[1]);
          mismatches++;
        end
        if (out_tdata[13:2] !== want.avg) begin
          if (mismatches < 20)
            $display("%0t: average expected %0d got %0d", $time, want.avg, out_tdata[13:2]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_LOW;
    cfg_wdata <= '0;
    for (int i = 0; i < WIN; i++) ring[i] = '0;
    slot           = 0;
    win_sum        = '0;
    avg_held       = '0;
    low_thr        = LOW_RST;
    high_thr       = HIGH_RST;
    ctrl_st        = 1'b0;
    lamp_lvl       = 1'b0;
    stat_flag      = 1'b0;
    src_gap_pct    = 10;
    sink_gap_pct   = 10;
    stall_request  = 1'b0;
    mismatches     = 0;
    words_sent     = 0;
    words_checked  = 0;
    reg_writes     = 0;
    ready_low_seen = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on();
    test_forced_commands();
    test_threshold_corners();
    test_random_batches();
    test_backpressure();
    test_closing_burst();

    wait_idle();
    $display("Sent %0d words, checked %0d results, %0d threshold writes, input held %0d cycles.",
             words_sent, words_checked, reg_writes, ready_low_seen);
    $display("Covered hold/auto/force commands, crossed and extreme thresholds, long output hold.");
    if (mismatches == 0 && lamp_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
